// File: rtl/lef_pkg.sv
// ----------------------------------------------------------------------------
// Line editor package
// Shared sizes, request codes, control characters and memory port types.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int unsigned LINE_DEPTH = 32;
  localparam int unsigned ECHO_DEPTH = 64;

  localparam int unsigned LINE_AW = $clog2(LINE_DEPTH);
  localparam int unsigned ECHO_AW = $clog2(ECHO_DEPTH);

  // Fixed field widths of the request and response channels
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned LENGTH_W = 5;
  localparam int unsigned LEVEL_W  = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_RX_BYTE   = 2'd0,
    REQ_POP_ECHO  = 2'd1,
    REQ_READ_LINE = 2'd2,
    REQ_RELEASE   = 2'd3
  } req_type_e;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

  typedef struct packed {
    logic               we;
    logic [LINE_AW-1:0] addr;
    logic [BYTE_W-1:0]  wdata;
  } line_mem_req_t;

  typedef struct packed {
    logic               we;
    logic [ECHO_AW-1:0] addr;
    logic [BYTE_W-1:0]  wdata;
  } echo_mem_req_t;

  typedef struct packed {
    logic               busy;
    logic [ECHO_AW-1:0] echo_level;
  } lef_stat_t;

  function automatic logic [ECHO_AW-1:0] ring_next(input logic [ECHO_AW-1:0] p);
    logic [ECHO_AW-1:0] r;
    if (int'(p) + 1 >= int'(ECHO_DEPTH)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/lef_req_if.sv
// ----------------------------------------------------------------------------
// Line editor request channel
// Valid/ready channel carrying one editor request.
// ----------------------------------------------------------------------------
interface lef_req_if;
  logic                          valid;
  logic                          ready;
  logic [lef_pkg::REQ_W-1:0]     req_type;
  logic [lef_pkg::BYTE_W-1:0]    rx_byte;
  logic [lef_pkg::INDEX_W-1:0]   line_index;

  modport source (output valid, output req_type, output rx_byte, output line_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input line_index,
                  output ready);
endinterface

// File: rtl/lef_rsp_if.sv
// ----------------------------------------------------------------------------
// Line editor response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface lef_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          echo_valid;
  logic [lef_pkg::BYTE_W-1:0]    echo_byte;
  logic [lef_pkg::BYTE_W-1:0]    line_char;
  logic [lef_pkg::LENGTH_W-1:0]  line_length;
  logic                          line_ready;
  logic [lef_pkg::LEVEL_W-1:0]   echo_level;

  modport source (output valid, output echo_valid, output echo_byte, output line_char,
                  output line_length, output line_ready, output echo_level,
                  input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input line_char,
                  input line_length, input line_ready, input echo_level,
                  output ready);
endinterface

// File: rtl/lef_ram.sv
// ----------------------------------------------------------------------------
// Line editor RAM
// Single-port synchronous RAM, write or registered read in each cycle.
// ----------------------------------------------------------------------------
module lef_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lef_ctrl.sv
// ----------------------------------------------------------------------------
// Line editor sequencer
// Decodes requests, keeps line length and echo pointers, drives both RAMs
// and holds the response register.
// ----------------------------------------------------------------------------
module lef_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lef_req_if.sink                req_i,
  lef_rsp_if.source              rsp_o,
  output lef_pkg::line_mem_req_t line_mem_o,
  input  logic [lef_pkg::BYTE_W-1:0] line_rdata_i,
  output lef_pkg::echo_mem_req_t echo_mem_o,
  input  logic [lef_pkg::BYTE_W-1:0] echo_rdata_i,
  output lef_pkg::lef_stat_t     stat_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUT,
    S_POP,
    S_READ
  } state_e;

  state_e                            state_q, state_d;
  logic [lef_pkg::LINE_AW-1:0]       count_q, count_d;
  logic                              done_q, done_d;
  logic [lef_pkg::ECHO_AW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [lef_pkg::BYTE_W-1:0]        put_q [3];
  logic [lef_pkg::BYTE_W-1:0]        put_d [3];
  logic [1:0]                        left_q, left_d;
  logic                              idx_ok_q, idx_ok_d;

  logic                              rsp_valid_q, rsp_valid_d;
  logic                              evalid_q, evalid_d;
  logic [lef_pkg::BYTE_W-1:0]        ebyte_q, ebyte_d;
  logic [lef_pkg::BYTE_W-1:0]        lchar_q, lchar_d;
  logic [lef_pkg::LENGTH_W-1:0]      length_q, length_d;
  logic                              lready_q, lready_d;
  logic [lef_pkg::LEVEL_W-1:0]       level_q, level_d;

  logic                              accept;
  logic                              load;
  logic                              ld_evalid;
  logic [lef_pkg::BYTE_W-1:0]        ld_ebyte, ld_lchar;
  logic [lef_pkg::ECHO_AW-1:0]       wr_next;
  logic                              full, empty;
  logic [lef_pkg::ECHO_AW-1:0]       level_now, level_nxt;
  lef_pkg::req_type_e                req_type;
  logic [lef_pkg::BYTE_W-1:0]        b;

  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign req_type    = lef_pkg::req_type_e'(req_i.req_type);
  assign b           = req_i.rx_byte;

  assign wr_next = lef_pkg::ring_next(wr_q);
  assign full    = (wr_next == rd_q);
  assign empty   = (wr_q == rd_q);

  always_comb begin
    level_now = wr_q - rd_q;
    if (wr_q < rd_q) begin
      level_now = level_now + lef_pkg::ECHO_AW'(lef_pkg::ECHO_DEPTH);
    end
    level_nxt = wr_d - rd_d;
    if (wr_d < rd_d) begin
      level_nxt = level_nxt + lef_pkg::ECHO_AW'(lef_pkg::ECHO_DEPTH);
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    done_d     = done_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    put_d      = put_q;
    left_d     = left_q;
    idx_ok_d   = idx_ok_q;
    load       = 1'b0;
    ld_evalid  = 1'b0;
    ld_ebyte   = '0;
    ld_lchar   = '0;
    line_mem_o = '{we: 1'b0, addr: count_q, wdata: lef_pkg::CH_NUL};
    echo_mem_o = '{we: 1'b0, addr: rd_q, wdata: put_q[0]};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            lef_pkg::REQ_RX_BYTE: begin
              priority if (b == lef_pkg::CH_CR || b == lef_pkg::CH_LF) begin
                line_mem_o.we = 1'b1;
                done_d        = 1'b1;
                put_d[0]      = lef_pkg::CH_CR;
                put_d[1]      = lef_pkg::CH_LF;
                left_d        = 2'd2;
                state_d       = S_PUT;
              end else if (b == lef_pkg::CH_BS || b == lef_pkg::CH_DEL) begin
                if (count_q != '0) begin
                  count_d  = count_q - 1'b1;
                  put_d[0] = lef_pkg::CH_BS;
                  put_d[1] = lef_pkg::CH_SPACE;
                  put_d[2] = lef_pkg::CH_BS;
                  left_d   = 2'd3;
                  state_d  = S_PUT;
                end else begin
                  load = 1'b1;
                end
              end else if (int'(count_q) < int'(lef_pkg::LINE_DEPTH) - 1) begin
                line_mem_o.we    = 1'b1;
                line_mem_o.wdata = b;
                count_d          = count_q + 1'b1;
                put_d[0]         = b;
                left_d           = 2'd1;
                state_d          = S_PUT;
              end else begin
                load = 1'b1;
              end
            end
            lef_pkg::REQ_POP_ECHO: begin
              if (!empty) begin
                rd_d    = lef_pkg::ring_next(rd_q);
                state_d = S_POP;
              end else begin
                load = 1'b1;
              end
            end
            lef_pkg::REQ_READ_LINE: begin
              line_mem_o.addr = lef_pkg::LINE_AW'(req_i.line_index);
              idx_ok_d        = (int'(req_i.line_index) < int'(lef_pkg::LINE_DEPTH));
              state_d         = S_READ;
            end
            lef_pkg::REQ_RELEASE: begin
              count_d = '0;
              done_d  = 1'b0;
              load    = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_PUT: begin
        // Queue one echo byte a cycle; drop it when the ring is full
        if (!full) begin
          echo_mem_o.we   = 1'b1;
          echo_mem_o.addr = wr_q;
          wr_d            = wr_next;
        end
        put_d[0] = put_q[1];
        put_d[1] = put_q[2];
        left_d   = left_q - 1'b1;
        if (left_q == 2'd1) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        load      = 1'b1;
        ld_evalid = 1'b1;
        ld_ebyte  = echo_rdata_i;
        state_d   = S_IDLE;
      end
      S_READ: begin
        load     = 1'b1;
        ld_lchar = idx_ok_q ? line_rdata_i : lef_pkg::CH_NUL;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    evalid_d    = evalid_q;
    ebyte_d     = ebyte_q;
    lchar_d     = lchar_q;
    length_d    = length_q;
    lready_d    = lready_q;
    level_d     = level_q;
    if (load) begin
      rsp_valid_d = 1'b1;
      evalid_d    = ld_evalid;
      ebyte_d     = ld_ebyte;
      lchar_d     = ld_lchar;
      length_d    = lef_pkg::LENGTH_W'(count_d);
      lready_d    = done_d;
      level_d     = lef_pkg::LEVEL_W'(level_nxt);
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      done_q      <= 1'b0;
      wr_q        <= '0;
      rd_q        <= '0;
      put_q       <= '{default: '0};
      left_q      <= '0;
      idx_ok_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
      evalid_q    <= 1'b0;
      ebyte_q     <= '0;
      lchar_q     <= '0;
      length_q    <= '0;
      lready_q    <= 1'b0;
      level_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      done_q      <= done_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      put_q       <= put_d;
      left_q      <= left_d;
      idx_ok_q    <= idx_ok_d;
      rsp_valid_q <= rsp_valid_d;
      evalid_q    <= evalid_d;
      ebyte_q     <= ebyte_d;
      lchar_q     <= lchar_d;
      length_q    <= length_d;
      lready_q    <= lready_d;
      level_q     <= level_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.echo_valid  = evalid_q;
  assign rsp_o.echo_byte   = ebyte_q;
  assign rsp_o.line_char   = lchar_q;
  assign rsp_o.line_length = length_q;
  assign rsp_o.line_ready  = lready_q;
  assign rsp_o.echo_level  = level_q;

  assign stat_o = '{busy: (state_q != S_IDLE), echo_level: level_now};

endmodule

// File: rtl/line_editor_with_echo_fifo.sv
// ----------------------------------------------------------------------------
// Serial line editor with local echo
// Edits a terminal line held in a line RAM and queues echo bytes in a ring
// held in a second RAM; pops echo bytes, reads line characters, releases.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  --------------------------------------------------
//  req_i     in         req_type, rx_byte, line_index
//  rsp_o     out        echo_valid, echo_byte, line_char, line_length,
//                       line_ready, echo_level
//
// Release, a pop from an empty ring and a received byte that queues no echo
// (line full, or an erase on an empty line) load the response register
// straight from idle; a pop or a line read first waits for the registered
// RAM read; any other received byte first offers its echo bytes to the ring
// in turn, kept or dropped, through the single write port of the echo RAM.
// Reset clears line length, line-ready flag and both ring pointers; RAM
// contents are left as they are. A request is taken only while the
// sequencer is idle and the response register is free or being emptied.
//
module line_editor_with_echo_fifo (
  input  logic      clk_i,
  input  logic      rst_ni,
  lef_req_if.sink   req_i,
  lef_rsp_if.source rsp_o
);

  lef_pkg::line_mem_req_t       line_mem;
  lef_pkg::echo_mem_req_t       echo_mem;
  logic [lef_pkg::BYTE_W-1:0]   line_rdata;
  logic [lef_pkg::BYTE_W-1:0]   echo_rdata;
  lef_pkg::lef_stat_t           stat;

  // Sequencer: decode, pointer and length bookkeeping, response register
  lef_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .line_mem_o   (line_mem),
    .line_rdata_i (line_rdata),
    .echo_mem_o   (echo_mem),
    .echo_rdata_i (echo_rdata),
    .stat_o       (stat)
  );

  // Line store: typed characters and the terminator
  lef_ram #(
    .DEPTH (lef_pkg::LINE_DEPTH),
    .WIDTH (lef_pkg::BYTE_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_mem.we),
    .addr_i  (line_mem.addr),
    .wdata_i (line_mem.wdata),
    .rdata_o (line_rdata)
  );

  // Echo ring: bytes waiting to go back to the terminal
  lef_ram #(
    .DEPTH (lef_pkg::ECHO_DEPTH),
    .WIDTH (lef_pkg::BYTE_W)
  ) u_echo_ram (
    .clk_i   (clk_i),
    .we_i    (echo_mem.we),
    .addr_i  (echo_mem.addr),
    .wdata_i (echo_mem.wdata),
    .rdata_o (echo_rdata)
  );

  // A request is never taken while an untaken response would be overwritten
  a_no_rsp_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> (!rsp_o.valid || rsp_o.ready))
    else $error("request taken over a pending response");

  // Echo bytes are written only while there is room in the ring
  a_echo_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_mem.we |-> (int'(stat.echo_level) < int'(lef_pkg::ECHO_DEPTH) - 1))
    else $error("echo byte written into a full ring");

  // A fresh response leaves the sequencer idle
  a_rsp_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> !stat.busy)
    else $error("response raised while sequencer busy");

endmodule

// File: tb/editor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line editor response checker
// Watches the request and response channels, predicts each response from
// its own model of the line store and the echo ring, and compares.
// ----------------------------------------------------------------------------
module editor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lef_req_if          req_mon,
  lef_rsp_if          rsp_mon,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o,
  output int unsigned checked_count_o,
  output int unsigned echo_drop_count_o,
  output int unsigned line_drop_count_o
);

  typedef struct packed {
    logic                         echo_valid;
    logic [lef_pkg::BYTE_W-1:0]   echo_byte;
    logic [lef_pkg::BYTE_W-1:0]   line_char;
    logic [lef_pkg::LENGTH_W-1:0] line_length;
    logic                         line_ready;
    logic [lef_pkg::LEVEL_W-1:0]  echo_level;
  } editor_result_t;

  // Model state
  logic [lef_pkg::BYTE_W-1:0] line_mem [lef_pkg::LINE_DEPTH];
  logic [lef_pkg::BYTE_W-1:0] echo_ring [lef_pkg::ECHO_DEPTH];
  int unsigned       line_len;
  logic              line_flag;
  int unsigned       echo_wr;
  int unsigned       echo_rd;

  editor_result_t    expected_results [$];
  int unsigned       mismatches;
  int unsigned       checked;
  int unsigned       echo_drops;
  int unsigned       line_drops;

  assign mismatch_count_o  = mismatches;
  assign outstanding_o     = expected_results.size();
  assign checked_count_o   = checked;
  assign echo_drop_count_o = echo_drops;
  assign line_drop_count_o = line_drops;

  initial begin
    mismatches = 0;
    checked    = 0;
    echo_drops = 0;
    line_drops = 0;
  end

  function automatic int unsigned next_slot(input int unsigned p);
    return (p == lef_pkg::ECHO_DEPTH - 1) ? 0 : p + 1;
  endfunction

  // Drop the byte when the ring already holds ECHO_DEPTH-1 entries
  task automatic queue_echo(input logic [lef_pkg::BYTE_W-1:0] b);
    int unsigned nxt;
    nxt = next_slot(echo_wr);
    if (nxt != echo_rd) begin
      echo_ring[echo_wr] = b;
      echo_wr = nxt;
    end else begin
      echo_drops++;
    end
  endtask

  task automatic edit_line(input logic [lef_pkg::BYTE_W-1:0] b);
    if (b == lef_pkg::CH_CR || b == lef_pkg::CH_LF) begin
      if (line_len < lef_pkg::LINE_DEPTH) line_mem[line_len] = lef_pkg::CH_NUL;
      line_flag = 1'b1;
      queue_echo(lef_pkg::CH_CR);
      queue_echo(lef_pkg::CH_LF);
    end else if (b == lef_pkg::CH_BS || b == lef_pkg::CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        queue_echo(lef_pkg::CH_BS);
        queue_echo(lef_pkg::CH_SPACE);
        queue_echo(lef_pkg::CH_BS);
      end
    end else if (line_len < lef_pkg::LINE_DEPTH - 1) begin
      line_mem[line_len] = b;
      line_len++;
      queue_echo(b);
    end else begin
      line_drops++;
    end
  endtask

  task automatic predict_response(input lef_pkg::req_type_e kind,
                                  input logic [lef_pkg::BYTE_W-1:0] b,
                                  input logic [lef_pkg::INDEX_W-1:0] idx,
                                  output editor_result_t r);
    r = '0;
    case (kind)
      lef_pkg::REQ_RX_BYTE: begin
        edit_line(b);
      end
      lef_pkg::REQ_POP_ECHO: begin
        if (echo_rd != echo_wr) begin
          r.echo_valid = 1'b1;
          r.echo_byte  = echo_ring[echo_rd];
          echo_rd      = next_slot(echo_rd);
        end
      end
      lef_pkg::REQ_READ_LINE: begin
        if (int'(idx) < lef_pkg::LINE_DEPTH) r.line_char = line_mem[idx];
      end
      default: begin
        line_len  = 0;
        line_flag = 1'b0;
      end
    endcase
    r.line_length = lef_pkg::LENGTH_W'(line_len);
    r.line_ready  = line_flag;
    r.echo_level  = lef_pkg::LEVEL_W'((echo_wr + lef_pkg::ECHO_DEPTH - echo_rd)
                                      % lef_pkg::ECHO_DEPTH);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    editor_result_t want;
    editor_result_t fresh;
    if (!rst_ni) begin
      line_len  = 0;
      line_flag = 1'b0;
      echo_wr   = 0;
      echo_rd   = 0;
      expected_results.delete();
    end else begin
      // Compare the response first: it always belongs to an older request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("echo_valid", want.echo_valid, rsp_mon.echo_valid);
          check_field("echo_byte", want.echo_byte, rsp_mon.echo_byte);
          check_field("line_char", want.line_char, rsp_mon.line_char);
          check_field("line_length", want.line_length, rsp_mon.line_length);
          check_field("line_ready", want.line_ready, rsp_mon.line_ready);
          check_field("echo_level", want.echo_level, rsp_mon.echo_level);
          checked++;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_response(lef_pkg::req_type_e'(req_mon.req_type), req_mon.rx_byte,
                         req_mon.line_index, fresh);
        expected_results.push_back(fresh);
      end
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line editor testbench
// Drives terminal bytes, echo pops, line reads and releases into the editor
// with random gaps and response back-pressure; a checker beside the block
// predicts every response and the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned TOTAL_ITEMS    = 1850;
  localparam int unsigned QUIET_FROM     = TOTAL_ITEMS - 200;
  // No request and no stall on either side lasts this long, so this many
  // cycles without any handshake means the block has hung.
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned DRAIN_CYCLES   = 16;

  logic clk;
  logic rst_n;

  lef_req_if req_ch ();
  lef_rsp_if rsp_ch ();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned checked_count;
  int unsigned echo_drop_count;
  int unsigned line_drop_count;

  int unsigned items_sent;
  int unsigned kind_count [4];
  bit          quiet_phase;

  line_editor_with_echo_fifo dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  editor_checker checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .req_mon           (req_ch),
    .rsp_mon           (rsp_ch),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding),
    .checked_count_o   (checked_count),
    .echo_drop_count_o (echo_drop_count),
    .line_drop_count_o (line_drop_count)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------

  // Present one request, hold it until the editor takes it, then now and
  // again drop valid for a random burst so gaps land on every phase.
  task automatic issue(input lef_pkg::req_type_e kind,
                       input logic [lef_pkg::BYTE_W-1:0] b,
                       input logic [lef_pkg::INDEX_W-1:0] idx);
    int unsigned gap;
    req_ch.req_type   <= kind;
    req_ch.rx_byte    <= b;
    req_ch.line_index <= idx;
    req_ch.valid      <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    kind_count[kind]++;
    quiet_phase = (items_sent >= QUIET_FROM);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Fields a request does not use carry random values; the editor ignores them
  task automatic send_byte(input logic [lef_pkg::BYTE_W-1:0] b);
    issue(lef_pkg::REQ_RX_BYTE, b, lef_pkg::INDEX_W'($urandom));
  endtask

  task automatic send_pop();
    issue(lef_pkg::REQ_POP_ECHO, lef_pkg::BYTE_W'($urandom), lef_pkg::INDEX_W'($urandom));
  endtask

  task automatic send_read(input logic [lef_pkg::INDEX_W-1:0] idx);
    issue(lef_pkg::REQ_READ_LINE, lef_pkg::BYTE_W'($urandom), idx);
  endtask

  task automatic send_release();
    issue(lef_pkg::REQ_RELEASE, lef_pkg::BYTE_W'($urandom), lef_pkg::INDEX_W'($urandom));
  endtask

  // Mostly printable characters, sometimes any byte at all
  function automatic logic [lef_pkg::BYTE_W-1:0] typed_char();
    if ($urandom_range(0, 7) == 0) return lef_pkg::BYTE_W'($urandom_range(0, 255));
    return lef_pkg::BYTE_W'($urandom_range(32, 126));
  endfunction

  // --------------------------------------------------------------------------
  // Response back-pressure: random bursts of ready low and high, always high
  // in the quiet phase at the end
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    bit          ready_now;
    hold      = 0;
    ready_now = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet_phase || !ready_now) begin
        ready_now = 1'b1;
        // Leave an occasional long stretch with no stalls at all
        hold = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 30);
      end else begin
        ready_now = 1'b0;
        hold = $urandom_range(0, 11);
      end
      if (quiet_phase) ready_now = 1'b1;
      rsp_ch.ready <= ready_now;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no request and no response moves for too long
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    logic [lef_pkg::BYTE_W-1:0] fill_chars [8];
    int unsigned       mode;
    int unsigned       r;
    fill_chars = '{8'h00, 8'hFF, 8'h80, 8'h7E, 8'h01, 8'h09, 8'hC3, 8'h55};
    items_sent  = 0;
    kind_count  = '{default: 0};
    quiet_phase = 1'b0;

    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= lef_pkg::REQ_RX_BYTE;
    req_ch.rx_byte    <= '0;
    req_ch.line_index <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Start on an empty editor: pop from an empty ring,
    // release an empty line, erase with nothing to erase.
    send_pop();
    send_release();
    send_byte(lef_pkg::CH_BS);
    send_byte(lef_pkg::CH_DEL);

    // Fill the line to its limit, starting with some extreme byte values; the
    // terminator that follows lands on the last position, so from here on every line
    // position has been written and any index may be read.
    for (int i = 0; i < lef_pkg::LINE_DEPTH - 1; i++) begin
      send_byte((i < 8) ? fill_chars[i] : lef_pkg::BYTE_W'(8'h41 + i));
    end
    send_byte(8'h5A);            // line full: dropped without echo
    send_byte(lef_pkg::CH_CR);
    send_byte(lef_pkg::CH_LF);   // second end of line after the line is ready
    send_read(lef_pkg::INDEX_W'(0));
    send_read(lef_pkg::INDEX_W'(lef_pkg::LINE_DEPTH - 1));
    send_read(lef_pkg::INDEX_W'(1));
    send_byte(lef_pkg::CH_BS);   // erase after ready
    send_byte(8'h61);            // append after ready
    send_byte(lef_pkg::CH_DEL);
    repeat (4) send_pop();
    send_release();              // store and ring are kept
    send_read(lef_pkg::INDEX_W'(5));
    send_pop();

    // Random part: mostly well-formed lines with random content, plus ring
    // drains, typing bursts that overrun the ring, and pure noise.
    while (items_sent < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 19);
      if (mode < 10) begin
        // Type a line, with the odd erase and an interleaved pop
        repeat ($urandom_range(0, 40)) begin
          r = $urandom_range(0, 19);
          if (r == 0) send_byte(lef_pkg::CH_BS);
          else if (r == 1) send_byte(lef_pkg::CH_DEL);
          else if (r < 5) send_pop();
          else send_byte(typed_char());
        end
        send_byte($urandom_range(0, 1) ? lef_pkg::CH_CR : lef_pkg::CH_LF);
        repeat ($urandom_range(0, 4)) send_read(lef_pkg::INDEX_W'($urandom_range(0, 31)));
        // Sometimes keep typing onto a ready line instead of releasing it
        if ($urandom_range(0, 3) != 0) send_release();
      end else if (mode < 14) begin
        // Drain the echo ring, often past empty
        repeat ($urandom_range(1, 70)) send_pop();
      end else if (mode < 17) begin
        // Type a burst without popping, which can overflow the ring
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 5) == 0) send_byte(lef_pkg::CH_BS);
          else send_byte(typed_char());
        end
      end else begin
        // Noise: any request with any field values
        repeat ($urandom_range(5, 30)) begin
          issue(lef_pkg::req_type_e'($urandom_range(0, 3)),
                lef_pkg::BYTE_W'($urandom_range(0, 255)),
                lef_pkg::INDEX_W'($urandom_range(0, 31)));
        end
      end
    end
    req_ch.valid <= 1'b0;

    // Wait for every outstanding response, then let the pipeline settle so a
    // stray extra response would still be caught.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d bytes, %0d pops, %0d reads, %0d releases; %0d checked.",
             items_sent, kind_count[lef_pkg::REQ_RX_BYTE], kind_count[lef_pkg::REQ_POP_ECHO],
             kind_count[lef_pkg::REQ_READ_LINE], kind_count[lef_pkg::REQ_RELEASE],
             checked_count);
    $display("Echo bytes lost to a full ring: %0d; characters lost to a full line: %0d.",
             echo_drop_count, line_drop_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
